// ----- sv/ssc_pkg.sv -----
// shared constants and helpers for the segment sphere contact generator
package ssc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int T_BITS        = 30;
    localparam int Q_BITS        = 15;
    localparam int UNIT_W        = 66;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int IN_DATA_W     = 160;
    localparam int OUT_DATA_W    = 96;
    localparam int OUT_USER_W    = 2;

    localparam logic [15:0] LIMIT_RESET = 16'd256;
    localparam logic [15:0] N_ONE       = 16'd16384;

    localparam logic [CFG_ADDR_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_END_X   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_END_Y   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_END_Z   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT   = 3'd6;

    localparam logic [1:0] REGION_START = 2'd0;
    localparam logic [1:0] REGION_END   = 2'd1;
    localparam logic [1:0] REGION_MID   = 2'd2;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        logic signed [31:0] r;
        if (x > 36'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        return v[31] ? 33'(-w) : 33'(w);
    endfunction

endpackage

// ----- sv/segment_sphere_contact_generator.sv -----
// sphere against line segment contact generator, one shared multiplier and subtract unit
// steps: DIFF, projection and segment length sums, REGION, then DIV and offset only in the middle,
// squared distance, HIT, SQRT, NORM and OUT; a miss ends at HIT, a request over the limit in IDLE
// throughput: one request at a time, paced by the serial divider and square root
// the output register lets the next request start while a contact waits
// reset (rst_n low, async): idle, no contact, segment zero, limit 256, count zero
module segment_sphere_contact_generator #(
    parameter int FRAC_BITS = ssc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sphere_id, pos_x, pos_y, pos_z, radius, bounciness
    input  logic [ssc_pkg::IN_DATA_W-1:0]         s_tdata,
    // pass_start
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // contact_id, normal_x, normal_y, penetration, restitution
    output logic [ssc_pkg::OUT_DATA_W-1:0]        m_tdata,
    // region
    output logic [ssc_pkg::OUT_USER_W-1:0]        m_tuser,
    input  logic                                  cfg_we,
    input  logic [ssc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int PW = 66 - FRAC_BITS;
    localparam int UW = ssc_pkg::UNIT_W;
    localparam int TB = ssc_pkg::T_BITS;
    localparam int QB = ssc_pkg::Q_BITS;

    typedef enum logic [4:0] {
        IDLE, DIFF, M_PROJ, A_PROJ, M_SEG, A_SEG, REGION, DIV, M_OFF, A_OFF,
        M_SQ, A_SQ, M_R2, HIT, SQRT, NORM, OUT
    } state_t;

    state_t                state_reg;
    logic signed [31:0]    start_reg [3];
    logic signed [31:0]    end_reg [3];
    logic [15:0]           limit_reg;
    logic [15:0]           used_reg;
    logic [15:0]           id_reg;
    logic signed [31:0]    pos_reg [3];
    logic [30:0]           radius_reg;
    logic [15:0]           bounce_reg;
    logic signed [31:0]    to_reg [3];
    logic signed [31:0]    line_reg [3];
    logic signed [31:0]    pe_reg [3];
    logic signed [31:0]    v_reg [3];
    logic signed [PW-1:0]  proj_reg;
    logic signed [PW-1:0]  seglen_reg;
    logic [TB-1:0]         t_reg;
    logic [UW-1:0]         rem_reg;
    logic [63:0]           d2_reg;
    logic [63:0]           res_reg;
    logic [63:0]           bit_reg;
    logic [QB-1:0]         q_reg;
    logic signed [15:0]    nx_reg;
    logic signed [15:0]    ny_reg;
    logic [1:0]            region_reg;
    logic                  comp_reg;
    logic signed [63:0]    prod_reg;
    logic [1:0]            idx_reg;
    logic [4:0]            cnt_reg;
    logic                  m_valid_reg;
    logic [ssc_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [ssc_pkg::OUT_USER_W-1:0] out_user_reg;

    logic signed [32:0]    mul_a;
    logic signed [32:0]    mul_b;
    logic signed [65:0]    prod_full;
    logic [UW-1:0]         sub_a;
    logic [UW-1:0]         sub_b;
    logic [UW:0]           sub_diff;
    logic                  sub_ge;
    logic [15:0]           used_eff;
    logic [QB-1:0]         q_next;
    logic [QB-1:0]         q_clamp;
    logic signed [15:0]    n_next;
    logic [31:0]           len;
    logic [30:0]           pen;
    logic                  out_free;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign used_eff = s_tuser[0] ? 16'd0 : used_reg;
    assign len      = res_reg[31:0];
    assign pen      = ({1'b0, radius_reg} > len) ? 31'({1'b0, radius_reg} - len) : 31'd0;
    assign out_free = !m_valid_reg || m_tready;

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            M_PROJ:
            begin
                mul_a = 33'(to_reg[idx_reg]);
                mul_b = 33'(line_reg[idx_reg]);
            end
            M_SEG:
            begin
                mul_a = 33'(line_reg[idx_reg]);
                mul_b = 33'(line_reg[idx_reg]);
            end
            M_OFF:
            begin
                mul_a = 33'(line_reg[idx_reg]);
                mul_b = $signed({3'b000, t_reg});
            end
            M_SQ:
            begin
                mul_a = 33'(v_reg[idx_reg]);
                mul_b = 33'(v_reg[idx_reg]);
            end
            M_R2:
            begin
                mul_a = $signed({2'b00, radius_reg});
                mul_b = $signed({2'b00, radius_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // shared subtract and compare unit
    always_comb
    begin
        sub_a = rem_reg;
        sub_b = '0;
        unique case (state_reg)
            DIV:
            begin
                sub_a = rem_reg << 1;
                sub_b = UW'($unsigned(seglen_reg));
            end
            SQRT:
            begin
                sub_a = rem_reg;
                sub_b = UW'({1'b0, res_reg} + {1'b0, bit_reg});
            end
            NORM:
            begin
                sub_a = (cnt_reg == 5'd0) ? rem_reg : (rem_reg << 1);
                sub_b = UW'(len);
            end
            default:
            begin
                sub_a = rem_reg;
                sub_b = '0;
            end
        endcase
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[UW];
    assign q_next   = {q_reg[QB-2:0], sub_ge};
    assign q_clamp  = (q_next > QB'(ssc_pkg::N_ONE)) ? QB'(ssc_pkg::N_ONE) : q_next;

    always_comb
    begin
        if (len == 32'd0)
            n_next = 16'sd0;
        else if (v_reg[{1'b0, comp_reg}][31])
            n_next = -$signed(16'(q_clamp));
        else
            n_next = $signed(16'(q_clamp));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            start_reg    <= '{default: '0};
            end_reg      <= '{default: '0};
            limit_reg    <= ssc_pkg::LIMIT_RESET;
            used_reg     <= '0;
            id_reg       <= '0;
            pos_reg      <= '{default: '0};
            radius_reg   <= '0;
            bounce_reg   <= '0;
            to_reg       <= '{default: '0};
            line_reg     <= '{default: '0};
            pe_reg       <= '{default: '0};
            v_reg        <= '{default: '0};
            proj_reg     <= '0;
            seglen_reg   <= '0;
            t_reg        <= '0;
            rem_reg      <= '0;
            d2_reg       <= '0;
            res_reg      <= '0;
            bit_reg      <= '0;
            q_reg        <= '0;
            nx_reg       <= '0;
            ny_reg       <= '0;
            region_reg   <= ssc_pkg::REGION_START;
            comp_reg     <= 1'b0;
            prod_reg     <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            out_data_reg <= '0;
            out_user_reg <= '0;
        end
        else
        begin
            prod_reg <= 64'(prod_full);

            if (cfg_we)
            begin
                case (cfg_addr)
                    ssc_pkg::REG_START_X: start_reg[0] <= $signed(cfg_wdata);
                    ssc_pkg::REG_START_Y: start_reg[1] <= $signed(cfg_wdata);
                    ssc_pkg::REG_START_Z: start_reg[2] <= $signed(cfg_wdata);
                    ssc_pkg::REG_END_X:   end_reg[0]   <= $signed(cfg_wdata);
                    ssc_pkg::REG_END_Y:   end_reg[1]   <= $signed(cfg_wdata);
                    ssc_pkg::REG_END_Z:   end_reg[2]   <= $signed(cfg_wdata);
                    ssc_pkg::REG_LIMIT:   limit_reg    <= cfg_wdata[15:0];
                    default:              limit_reg    <= limit_reg;
                endcase
            end

            if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        id_reg     <= s_tdata[15:0];
                        pos_reg[0] <= $signed(s_tdata[47:16]);
                        pos_reg[1] <= $signed(s_tdata[79:48]);
                        pos_reg[2] <= $signed(s_tdata[111:80]);
                        radius_reg <= s_tdata[142:112];
                        bounce_reg <= s_tdata[158:143];
                        used_reg   <= used_eff;
                        if (used_eff < limit_reg)
                            state_reg <= DIFF;
                    end
                end
                DIFF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        to_reg[i]   <= ssc_pkg::sat32(36'(pos_reg[i]) - 36'(start_reg[i]));
                        line_reg[i] <= ssc_pkg::sat32(36'(end_reg[i]) - 36'(start_reg[i]));
                        pe_reg[i]   <= ssc_pkg::sat32(36'(pos_reg[i]) - 36'(end_reg[i]));
                    end
                    idx_reg    <= '0;
                    proj_reg   <= '0;
                    seglen_reg <= '0;
                    d2_reg     <= '0;
                    state_reg  <= M_PROJ;
                end
                M_PROJ:
                begin
                    state_reg <= A_PROJ;
                end
                A_PROJ:
                begin
                    proj_reg <= proj_reg + PW'(prod_reg >>> FRAC_BITS);
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= M_SEG;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= M_PROJ;
                    end
                end
                M_SEG:
                begin
                    state_reg <= A_SEG;
                end
                A_SEG:
                begin
                    seglen_reg <= seglen_reg + PW'(prod_reg >>> FRAC_BITS);
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= REGION;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= M_SEG;
                    end
                end
                REGION:
                begin
                    idx_reg <= '0;
                    cnt_reg <= '0;
                    priority if (proj_reg <= 0)
                    begin
                        region_reg <= ssc_pkg::REGION_START;
                        v_reg      <= to_reg;
                        state_reg  <= M_SQ;
                    end
                    else if (proj_reg >= seglen_reg)
                    begin
                        region_reg <= ssc_pkg::REGION_END;
                        v_reg      <= pe_reg;
                        state_reg  <= M_SQ;
                    end
                    else
                    begin
                        region_reg <= ssc_pkg::REGION_MID;
                        rem_reg    <= UW'($unsigned(proj_reg));
                        t_reg      <= '0;
                        state_reg  <= DIV;
                    end
                end
                DIV:
                begin
                    rem_reg <= sub_ge ? sub_diff[UW-1:0] : sub_a;
                    t_reg   <= {t_reg[TB-2:0], sub_ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(TB - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= M_OFF;
                    end
                end
                M_OFF:
                begin
                    state_reg <= A_OFF;
                end
                A_OFF:
                begin
                    v_reg[idx_reg] <= ssc_pkg::sat32(36'(to_reg[idx_reg]) - 36'(prod_reg >>> TB));
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= M_SQ;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= M_OFF;
                    end
                end
                M_SQ:
                begin
                    state_reg <= A_SQ;
                end
                A_SQ:
                begin
                    d2_reg <= d2_reg + $unsigned(prod_reg);
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= M_R2;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= M_SQ;
                    end
                end
                M_R2:
                begin
                    state_reg <= HIT;
                end
                HIT:
                begin
                    if (d2_reg < $unsigned(prod_reg))
                    begin
                        used_reg  <= used_reg + 16'd1;
                        rem_reg   <= UW'(d2_reg);
                        res_reg   <= '0;
                        bit_reg   <= 64'd1 << 62;
                        cnt_reg   <= '0;
                        state_reg <= SQRT;
                    end
                    else
                    begin
                        state_reg <= IDLE;
                    end
                end
                SQRT:
                begin
                    if (sub_ge)
                    begin
                        rem_reg <= sub_diff[UW-1:0];
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        comp_reg  <= 1'b0;
                        rem_reg   <= UW'(ssc_pkg::mag33(v_reg[0]));
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= NORM;
                    end
                end
                NORM:
                begin
                    rem_reg <= sub_ge ? sub_diff[UW-1:0] : sub_a;
                    q_reg   <= q_next;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(QB - 1))
                    begin
                        if (!comp_reg)
                        begin
                            nx_reg   <= n_next;
                            comp_reg <= 1'b1;
                            rem_reg  <= UW'(ssc_pkg::mag33(v_reg[1]));
                            q_reg    <= '0;
                            cnt_reg  <= '0;
                        end
                        else
                        begin
                            ny_reg    <= n_next;
                            state_reg <= OUT;
                        end
                    end
                end
                OUT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        out_data_reg <= {1'b0, bounce_reg, pen, ny_reg, nx_reg, id_reg};
                        out_user_reg <= region_reg;
                        state_reg    <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/ssc_checker.sv -----
// port level checks for the segment sphere contact generator
module ssc_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [ssc_pkg::OUT_DATA_W-1:0]        m_tdata,
    input logic [ssc_pkg::OUT_USER_W-1:0]        m_tuser
);

    // stalled contact holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled contact changed");

    // region code is one of the three parts
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ssc_pkg::REGION_START || m_tuser == ssc_pkg::REGION_END
                      || m_tuser == ssc_pkg::REGION_MID))
        else $error("bad region code");

    // normals stay within unit range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd16384
                      && $signed(m_tdata[31:16]) >= -16'sd16384
                      && $signed(m_tdata[47:32]) <= 16'sd16384
                      && $signed(m_tdata[47:32]) >= -16'sd16384))
        else $error("normal out of range");

    // a contact always overlaps
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[78:48] != 31'd0 && m_tdata[95] == 1'b0)
        else $error("contact without penetration");

endmodule

bind segment_sphere_contact_generator ssc_checker u_ssc_checker (.*);
